### rtl/tkwc_pkg.sv
`timescale 1ns / 1ps

package tkwc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int WORD_W      = 32;
   localparam int IDX_W       = 8;
   localparam int MODE_W      = 2;

   // item modes
   localparam logic [MODE_W-1:0] MODE_TABLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DATA  = 2'd2;

   localparam logic [WORD_W-1:0] MIX_INIT = 32'hEEEE_EEEE;
   localparam logic [WORD_W-1:0] KEY_ADD  = 32'h1111_1111;
   localparam logic [WORD_W-1:0] MIX_ADD  = 32'd3;
   localparam int KEY_SHL = 21;
   localparam int KEY_SHR = 11;
   localparam int MIX_SHL = 5;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } tbl_wr_type;

   function automatic logic [WORD_W-1:0] next_key(input logic [WORD_W-1:0] k);
      return (((~k) << KEY_SHL) + KEY_ADD) | (k >> KEY_SHR);
   endfunction

endpackage

### rtl/table_keyed_word_cipher_core.sv
`timescale 1ns / 1ps

// table keyed word cipher core
//
// req channel: one word per handshake; req_mode picks a table load
// (req_table_index, req_table_word), a block start (req_block_key) or a
// data word (req_data_word). only data words give a result.
// rsp channel: one result word per data word, in order, from an output
// register; rsp_valid rises in the cycle after acceptance.
// csr channel: csr_direction (1 encrypts, 0 decrypts), always ready;
// write it only while the core is idle.
// throughput: one word per cycle unless the result stalls. the table
// entry for the next data word is read from the table ram as its key
// is registered, addressed by the next key, which never depends on the
// table. a table load that hits the entry being read is forwarded.
// reset: key seed 0, mix seed 0xEEEEEEEE, direction decrypt, output empty;
// table contents stay undefined until loaded. no clearing pass.
// stall: while rsp_valid is high and rsp_ready low, req_ready drops and
// the held result stays unchanged.
module table_keyed_word_cipher_core #(
   parameter int TABLE_DEPTH = tkwc_pkg::TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // request words
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tkwc_pkg::MODE_W-1:0] req_mode,
   input  logic [tkwc_pkg::IDX_W-1:0]  req_table_index,
   input  logic [tkwc_pkg::WORD_W-1:0] req_table_word,
   input  logic [tkwc_pkg::WORD_W-1:0] req_block_key,
   input  logic [tkwc_pkg::WORD_W-1:0] req_data_word,
   // result words
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tkwc_pkg::WORD_W-1:0] rsp_result_word,
   // direction register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_direction
);
   import tkwc_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   logic              req_fire;
   logic              data_fire;
   tbl_wr_type        tbl_wr;
   logic [WORD_W-1:0] tbl_entry;

   logic [WORD_W-1:0] key_ff, key_in;
   logic [WORD_W-1:0] mix_ff, mix_in;
   logic              dir_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] result_ff;

   // data word datapath
   logic [WORD_W-1:0] mix_sum;
   logic [WORD_W-1:0] result;
   logic [WORD_W-1:0] plain;
   logic [WORD_W-1:0] mix_new;

   // output register frees up when empty or being drained
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign data_fire = req_fire && (req_mode == MODE_DATA);
   assign csr_ready = 1'b1;

   // tbl_entry holds cipher_table[key_ff] (prefetched with key_in last edge)
   assign mix_sum = mix_ff + tbl_entry;
   assign result  = req_data_word ^ (key_ff + mix_sum);
   assign plain   = dir_ff ? req_data_word : result;
   assign mix_new = plain + mix_sum + (mix_sum << MIX_SHL) + MIX_ADD;

   always_comb begin
      key_in      = key_ff;
      mix_in      = mix_ff;
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = req_table_index;
      tbl_wr.data = req_table_word;
      if (reset) begin
         key_in = '0;
         mix_in = MIX_INIT;
      end else if (req_fire) begin
         unique case (req_mode)
            MODE_TABLE: begin
               tbl_wr.en = 1'b1;
            end
            MODE_START: begin
               key_in = req_block_key;
               mix_in = MIX_INIT;
            end
            MODE_DATA: begin
               key_in = next_key(key_ff);
               mix_in = mix_new;
            end
            default: begin
               // unused mode: no effect
            end
         endcase
      end
   end

   // table read is always addressed by the key of the next data word
   tkwc_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_addr (key_in[AW-1:0]),
      .entry   (tbl_entry)
   );

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      mix_ff <= mix_in;
      if (reset) begin
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            dir_ff <= csr_direction;
         end
         if (data_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (data_fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = result_ff;

endmodule

### rtl/tkwc_ram.sv
`timescale 1ns / 1ps

module tkwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tkwc_table.sv
`timescale 1ns / 1ps

module tkwc_table #(
   parameter int DEPTH = tkwc_pkg::TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tkwc_pkg::tbl_wr_type        wr,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [tkwc_pkg::WORD_W-1:0] entry
);
   import tkwc_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] rd_data;
   logic              hit_ff, hit_in;
   logic [WORD_W-1:0] fwd_ff;

   assign wr_addr = wr.addr[AW-1:0];

   tkwc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // write and read of the same entry at one edge: ram returns old data
   assign hit_in = wr.en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      fwd_ff <= wr.data;
   end

   assign entry = hit_ff ? fwd_ff : rd_data;

endmodule

### rtl/tkwc_checker.sv
`timescale 1ns / 1ps

module tkwc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [tkwc_pkg::MODE_W-1:0] req_mode,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tkwc_pkg::WORD_W-1:0] rsp_result_word
);
   import tkwc_pkg::*;

   // output empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // every data word gives a result in the next cycle
   a_data_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_DATA) |=> rsp_valid)
      else $error("data word without result");

   // other words give no result
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode != MODE_DATA && (!rsp_valid || rsp_ready))
      |=> !rsp_valid)
      else $error("result from a non-data word");

   // input only backs up behind a stalled result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without cause");

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_word)))
      else $error("stalled result changed");

endmodule

bind table_keyed_word_cipher_core tkwc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_word (rsp_result_word)
);
